// ----- rtl/assert_macros.svh -----
// assertion helpers for the serializer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHECK_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked on the following clock edge
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crws_pkg.sv -----
// ----------------------------------------------------------------------------
// crws_pkg
// shared types, constants and register tables of the write serializer
// ----------------------------------------------------------------------------
`default_nettype none

package crws_pkg;

    localparam int VALUE_COUNT_DEF = 17;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int IDX_W           = 5;
    localparam int VAL_W           = 48;

    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_MRESET = 3'd2;
    localparam logic [2:0] OP_LATCH  = 3'd3;
    localparam logic [2:0] OP_KEY    = 3'd4;
    localparam logic [2:0] OP_HOLD   = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_FORCE  = 3'd1;
    localparam logic [2:0] CFG_INDEP  = 3'd2;
    localparam logic [2:0] CFG_PREC   = 3'd3;
    localparam logic [2:0] CFG_DEVICE = 3'd4;
    localparam logic [2:0] CFG_BASE   = 3'd5;

    localparam logic [IDX_W-1:0] IDLE_MARK    = 5'd31;
    localparam logic [IDX_W-1:0] UPDATE_VALUE = 5'd14;
    localparam logic [IDX_W-1:0] RESET_STROBE = 5'd15;
    localparam logic [IDX_W-1:0] LATCH_STROBE = 5'd16;

    localparam logic [7:0] KEY_BIT  = 8'h80;
    localparam logic [7:0] HOLD_BIT = 8'h40;

    typedef struct packed {
        logic       independent_update;
        logic [2:0] frequency_precision;
        logic [5:0] device_address;
        logic [15:0] bus_base;
    } cfg_t;

    function automatic logic [2:0] val_len(input logic [IDX_W-1:0] i);
        logic [2:0] l;
        l = 3'd1;
        case (i)
            5'd0, 5'd1, 5'd7, 5'd9: l = 3'd2;
            5'd2, 5'd3, 5'd4:       l = 3'd6;
            5'd5:                   l = 3'd4;
            5'd6:                   l = 3'd3;
            default:                l = 3'd1;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] val_reg(input logic [IDX_W-1:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (i)
            5'd0:  r = 8'h00;
            5'd1:  r = 8'h02;
            5'd2:  r = 8'h04;
            5'd3:  r = 8'h0A;
            5'd4:  r = 8'h10;
            5'd5:  r = 8'h16;
            5'd6:  r = 8'h1A;
            5'd7:  r = 8'h21;
            5'd8:  r = 8'h25;
            5'd9:  r = 8'h26;
            5'd10: r = 8'h1D;
            5'd11: r = 8'h1E;
            5'd12: r = 8'h1F;
            5'd13: r = 8'h20;
            5'd14: r = 8'h30;
            5'd15: r = 8'h31;
            5'd16: r = 8'h32;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] val_default(input logic [IDX_W-1:0] i);
        logic [VAL_W-1:0] d;
        d = '0;
        case (i)
            5'd5:  d = 48'h40;
            5'd10: d = 48'h10;
            5'd11: d = 48'h64;
            5'd12: d = 48'h01;
            5'd13: d = 48'h20;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/crws_ram.sv -----
// ----------------------------------------------------------------------------
// crws_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module crws_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/crws_queue.sv -----
// ----------------------------------------------------------------------------
// crws_queue
// ring of pending value numbers with a registered head word
// ----------------------------------------------------------------------------
`default_nettype none

module crws_queue #(
    parameter int QUEUE_DEPTH = crws_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         flush,
    input  wire logic                         push,
    input  wire logic [crws_pkg::IDX_W-1:0]   push_idx,
    input  wire logic                         pop,
    output logic                              full,
    output logic                              empty,
    output logic      [crws_pkg::IDX_W-1:0]   head_idx
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [crws_pkg::IDX_W-1:0] rdata;
    // bypass: head read last cycle may be stale if written at that address
    logic                       byp_reg, byp_next;
    logic [crws_pkg::IDX_W-1:0] byp_val_reg;
    logic [PW-1:0] head_n1, tail_n1;

    assign head_n1 = (head_reg == LAST_P) ? '0 : head_reg + 1'b1;
    assign tail_n1 = (tail_reg == LAST_P) ? '0 : tail_reg + 1'b1;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (flush)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        if (pop)
        begin
            head_next  = head_n1;
            count_next = count_next - 1'b1;
        end
        if (push)
        begin
            tail_next  = flush ? PW'(1) : tail_n1;
            count_next = count_next + 1'b1;
        end
        byp_next = push && ((flush ? '0 : tail_reg) == head_next);
    end

    crws_ram #(
        .WIDTH (crws_pkg::IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (flush ? '0 : tail_reg),
        .wdata (push_idx),
        .raddr (head_next),
        .rdata (rdata)
    );

    assign head_idx = byp_reg ? byp_val_reg : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            byp_reg   <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_val_reg <= push_idx;
    end

endmodule

`default_nettype wire

// ----- rtl/crws_back.sv -----
// ----------------------------------------------------------------------------
// crws_back
// byte sequencer: takes a value from the queue and forms bus words
// ----------------------------------------------------------------------------
`default_nettype none

module crws_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire crws_pkg::cfg_t                cfg,
    input  wire logic                          clear,
    input  wire logic                          tick,
    input  wire logic                          q_empty,
    input  wire logic [crws_pkg::IDX_W-1:0]    q_head,
    input  wire logic [crws_pkg::VAL_W-1:0]    head_contents,
    input  wire logic                          keying,
    input  wire logic                          hold,
    output logic                               pop,
    output logic                               wr_valid,
    output logic      [15:0]                   wr_address,
    output logic      [15:0]                   wr_data
);

    logic [crws_pkg::IDX_W-1:0] act_reg, act_next, a;
    logic [crws_pkg::VAL_W-1:0] cont_reg, cont_next, c;
    logic [2:0] pos_reg, pos_next, p, len, prec, fp, start;
    logic [7:0] base, reg_no, data_byte;
    logic [1:0] offset;
    logic last;

    always_comb
    begin
        pop      = 1'b0;
        wr_valid = 1'b0;
        act_next = act_reg;
        cont_next = cont_reg;
        pos_next = pos_reg;
        a = act_reg;
        c = cont_reg;
        p = pos_reg;
        if (act_reg == crws_pkg::IDLE_MARK)
        begin
            a = (q_head > 5'd16) ? '0 : q_head;
            c = head_contents;
        end
        len  = crws_pkg::val_len(a) + {2'b0, cfg.independent_update};
        fp   = (cfg.frequency_precision == 3'd0) ? 3'd1 :
               (cfg.frequency_precision == 3'd7) ? 3'd6 : cfg.frequency_precision;
        prec = fp + {2'b0, cfg.independent_update};
        start = ((a == 5'd2 || a == 5'd3) && len > prec) ? len - prec : 3'd0;
        if (act_reg == crws_pkg::IDLE_MARK)
        begin
            p = start;
        end
        base = crws_pkg::val_reg(a) - {7'b0, cfg.independent_update};
        reg_no = base + {5'b0, len} - {5'b0, p} - 8'd1
               + (keying ? crws_pkg::KEY_BIT : 8'h00)
               + (hold ? crws_pkg::HOLD_BIT : 8'h00);
        // the extra byte of a long value lies above the 48 stored bits
        data_byte = (p >= 3'd6) ? 8'h00 : c[{p, 3'b000} +: 8];
        last = (p + 3'd1) >= len;
        unique case (a)
            crws_pkg::UPDATE_VALUE: offset = 2'd2;
            crws_pkg::RESET_STROBE: offset = 2'd0;
            crws_pkg::LATCH_STROBE: offset = 2'd3;
            default:                offset = 2'd1;
        endcase
        if (last && a != crws_pkg::RESET_STROBE && a != crws_pkg::LATCH_STROBE)
        begin
            offset = offset + 2'd1;
        end
        if (tick && !(act_reg == crws_pkg::IDLE_MARK && q_empty))
        begin
            wr_valid  = 1'b1;
            pop       = (act_reg == crws_pkg::IDLE_MARK);
            act_next  = last ? crws_pkg::IDLE_MARK : a;
            cont_next = c;
            pos_next  = last ? 3'd0 : p + 3'd1;
        end
        if (clear)
        begin
            act_next = crws_pkg::IDLE_MARK;
            pos_next = 3'd0;
        end
        wr_address = cfg.bus_base + {8'b0, cfg.device_address, 2'b00} + {14'b0, offset};
        wr_data    = {data_byte, reg_no};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= crws_pkg::IDLE_MARK;
            pos_reg <= 3'd0;
        end
        else
        begin
            act_reg <= act_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cont_reg <= cont_next;
    end

endmodule

`default_nettype wire

// ----- rtl/coalescing_register_write_serializer_unit.sv -----
// ----------------------------------------------------------------------------
// coalescing_register_write_serializer_unit
// front end keeps shadow values and queues changed ones; back end sends bytes
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start & !busy        opcode, value_index, value, flag_value
//  result    done (one cycle)     write_valid, bus_address, bus_data,
//                                 read_data, overflow
//  config    cfg_we               cfg_index, cfg_data
//
// a command is accepted when start is high and busy is low. busy and the
// result strobe are both high in the cycle after acceptance, while the queue
// head ram read settles. reset clears shadows to defaults, the queue and the
// sequencer at once. results cannot be stalled.
`default_nettype none

module coalescing_register_write_serializer_unit #(
    parameter int QUEUE_DEPTH = crws_pkg::QUEUE_DEPTH_DEF,
    parameter int VALUE_COUNT = crws_pkg::VALUE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [4:0]  value_index,
    input  wire logic [47:0] value,
    input  wire logic        flag_value,
    output logic             done,
    output logic             write_valid,
    output logic [15:0]      bus_address,
    output logic [15:0]      bus_data,
    output logic [47:0]      read_data,
    output logic             overflow,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

`include "assert_macros.svh"

    crws_pkg::cfg_t cfg_reg;
    logic enable_reg, force_reg;
    logic [47:0] shadow_reg [VALUE_COUNT];
    logic [VALUE_COUNT-1:0] mark_reg, mark_next;
    logic keying_reg, hold_reg;
    logic acc, idx_ok, q_full, q_empty, q_push, q_pop, q_flush, do_clear;
    logic [4:0] q_push_idx, q_head, hsel;
    logic [47:0] head_contents, cur;
    logic b_valid;
    logic [15:0] b_addr, b_data;
    logic done_reg, wv_reg, ovf_reg;
    logic [15:0] ba_reg, bd_reg;
    logic [47:0] rd_reg;
    logic ovf_c;
    logic [47:0] rd_c;
    logic busy_reg;

    assign acc    = start && !busy;
    assign busy   = busy_reg;
    assign idx_ok = value_index < 5'(VALUE_COUNT);
    assign cur    = idx_ok ? shadow_reg[value_index] : '0;
    assign hsel   = (q_head > 5'(VALUE_COUNT - 1)) ? '0 : q_head;
    assign head_contents = shadow_reg[hsel];

    always_comb
    begin
        q_push = 1'b0;
        q_push_idx = crws_pkg::LATCH_STROBE;
        q_flush = 1'b0;
        do_clear = 1'b0;
        ovf_c = 1'b0;
        rd_c = '0;
        mark_next = mark_reg;
        if (acc && enable_reg)
        begin
            unique case (opcode)
                crws_pkg::OP_SET:
                begin
                    if (idx_ok && (cur != value || force_reg))
                    begin
                        if (q_full)
                        begin
                            ovf_c = 1'b1;
                        end
                        else if (!mark_reg[value_index])
                        begin
                            q_push = 1'b1;
                            q_push_idx = value_index;
                        end
                    end
                end
                crws_pkg::OP_MRESET:
                begin
                    if (q_full)
                    begin
                        ovf_c = 1'b1;
                    end
                    else
                    begin
                        q_flush = 1'b1;
                        do_clear = 1'b1;
                        q_push = 1'b1;
                        q_push_idx = crws_pkg::RESET_STROBE;
                    end
                end
                crws_pkg::OP_LATCH, crws_pkg::OP_KEY, crws_pkg::OP_HOLD:
                begin
                    if (q_full)
                    begin
                        ovf_c = 1'b1;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                    if (opcode != crws_pkg::OP_LATCH)
                    begin
                        rd_c = {47'b0, flag_value};
                    end
                end
                crws_pkg::OP_READ:
                begin
                    rd_c = cur;
                end
                default:
                begin
                end
            endcase
        end
        if (q_pop)
        begin
            mark_next[hsel] = 1'b0;
        end
        // only sets mark a value as waiting, strobes never do
        if (q_push && opcode == crws_pkg::OP_SET)
        begin
            mark_next[q_push_idx] = 1'b1;
        end
        if (do_clear)
        begin
            mark_next = '0;
        end
    end

    crws_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (q_flush),
        .push     (q_push),
        .push_idx (q_push_idx),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_idx (q_head)
    );

    crws_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .clear         (do_clear),
        .tick          (acc && enable_reg && opcode == crws_pkg::OP_TICK),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .head_contents (head_contents),
        .keying        (keying_reg),
        .hold          (hold_reg),
        .pop           (q_pop),
        .wr_valid      (b_valid),
        .wr_address    (b_addr),
        .wr_data       (b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            force_reg  <= 1'b0;
            cfg_reg.independent_update  <= 1'b0;
            cfg_reg.frequency_precision <= 3'd6;
            cfg_reg.device_address      <= '0;
            cfg_reg.bus_base            <= '0;
            mark_reg   <= '0;
            keying_reg <= 1'b0;
            hold_reg   <= 1'b0;
            done_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            for (int i = 0; i < VALUE_COUNT; i++)
            begin
                shadow_reg[i] <= crws_pkg::val_default(5'(i));
            end
        end
        else
        begin
            done_reg <= acc;
            busy_reg <= acc;
            mark_reg <= mark_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    crws_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                    crws_pkg::CFG_FORCE:  force_reg  <= cfg_data[0];
                    crws_pkg::CFG_INDEP:  cfg_reg.independent_update  <= cfg_data[0];
                    crws_pkg::CFG_PREC:   cfg_reg.frequency_precision <= cfg_data[2:0];
                    crws_pkg::CFG_DEVICE: cfg_reg.device_address      <= cfg_data[5:0];
                    crws_pkg::CFG_BASE:   cfg_reg.bus_base            <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (do_clear)
            begin
                keying_reg <= 1'b0;
                hold_reg   <= 1'b0;
                for (int i = 0; i < VALUE_COUNT; i++)
                begin
                    shadow_reg[i] <= crws_pkg::val_default(5'(i));
                end
            end
            else if (acc && enable_reg)
            begin
                if (opcode == crws_pkg::OP_KEY)
                begin
                    keying_reg <= flag_value;
                end
                if (opcode == crws_pkg::OP_HOLD)
                begin
                    hold_reg <= flag_value;
                end
                if (opcode == crws_pkg::OP_SET && idx_ok && !ovf_c
                    && (cur != value || force_reg))
                begin
                    shadow_reg[value_index] <= value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= b_valid;
        ba_reg  <= b_valid ? b_addr : '0;
        bd_reg  <= b_valid ? b_data : '0;
        rd_reg  <= rd_c;
        ovf_reg <= ovf_c;
    end

    assign done        = done_reg;
    assign write_valid = done_reg & wv_reg;
    assign bus_address = done_reg ? ba_reg : '0;
    assign bus_data    = done_reg ? bd_reg : '0;
    assign read_data   = done_reg ? rd_reg : '0;
    assign overflow    = done_reg & ovf_reg;

    `CHECK_NEXT(a_done_follows, clk, rst_n, acc, done, "no result after accepted command")
    `CHECK_ALWAYS(a_busy_done, clk, rst_n, busy == done, "busy and result strobe disagree")
    `CHECK_ALWAYS(a_no_push_full, clk, rst_n, !(q_push && q_full && !q_flush),
        "push into a full queue")

endmodule

`default_nettype wire

// ----- tb/coalescing_register_write_serializer_unit_test.sv -----
// ----------------------------------------------------------------------------
// coalescing_register_write_serializer_unit_test
// drives random and directed commands through the serializer and checks
// every result strobe against a cycle-free shadow/queue predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module coalescing_register_write_serializer_unit_test;

    localparam int RING_SIZE   = 32;
    localparam int NUM_VALUES  = 17;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [4:0]  idx;
        logic [47:0] val;
        logic        flag;
    } command_t;

    typedef struct {
        logic        wv;
        logic [15:0] addr;
        logic [15:0] data;
        logic [47:0] rdata;
        logic        ovf;
    } bus_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] opcode;
    logic [4:0] value_index;
    logic [47:0] value;
    logic flag_value;
    logic done;
    logic write_valid;
    logic [15:0] bus_address;
    logic [15:0] bus_data;
    logic [47:0] read_data;
    logic overflow;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    coalescing_register_write_serializer_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .value_index(value_index), .value(value),
        .flag_value(flag_value), .done(done), .write_valid(write_valid),
        .bus_address(bus_address), .bus_data(bus_data), .read_data(read_data),
        .overflow(overflow), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // chip register layout
    localparam logic [2:0] LEN_TAB [NUM_VALUES] =
        '{3'd2, 3'd2, 3'd6, 3'd6, 3'd6, 3'd4, 3'd3, 3'd2, 3'd1, 3'd2,
          3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
    localparam logic [7:0] REG_TAB [NUM_VALUES] =
        '{8'h00, 8'h02, 8'h04, 8'h0A, 8'h10, 8'h16, 8'h1A, 8'h21, 8'h25, 8'h26,
          8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h30, 8'h31, 8'h32};

    // predictor configuration and state
    logic        p_enable, p_force, p_indep;
    logic [2:0]  p_prec;
    logic [5:0]  p_dev;
    logic [15:0] p_base;
    logic [47:0] shadow [NUM_VALUES];
    logic        marked [NUM_VALUES];
    logic [4:0]  ring [RING_SIZE];
    int          ring_rd, ring_wr, ring_used;
    logic [4:0]  cur_value;
    logic [47:0] cur_contents;
    int          cur_byte;
    logic        keying, holding;

    function automatic logic [47:0] default_contents(int i);
        case (i)
            5:  return 48'h40;
            10: return 48'h10;
            11: return 48'h64;
            12: return 48'h01;
            13: return 48'h20;
            default: return 48'h0;
        endcase
    endfunction

    function automatic void clear_shadows();
        for (int i = 0; i < NUM_VALUES; i++)
        begin
            shadow[i] = default_contents(i);
            marked[i] = 1'b0;
        end
        ring_rd = 0;
        ring_wr = 0;
        ring_used = 0;
        cur_value = crws_pkg::IDLE_MARK;
        cur_contents = '0;
        cur_byte = 0;
        keying = 1'b0;
        holding = 1'b0;
    endfunction

    function automatic bit enqueue(logic [4:0] v);
        if (ring_used >= RING_SIZE)
            return 1'b0;
        ring[ring_wr] = v;
        ring_wr = (ring_wr + 1) % RING_SIZE;
        ring_used++;
        return 1'b1;
    endfunction

    function automatic int byte_count(int i);
        return LEN_TAB[i] + p_indep;
    endfunction

    function automatic void emit_byte(ref bus_result_t r);
        int a, len, ofs, first, fp;
        logic [7:0] regnum, dbyte;
        if (cur_value == crws_pkg::IDLE_MARK)
        begin
            if (ring_used == 0)
                return;
            a = ring[ring_rd];
            cur_value = 5'(a);
            cur_contents = shadow[a];
            first = 0;
            if (a == 2 || a == 3)
            begin
                fp = p_prec;
                if (fp < 1) fp = 1;
                if (fp > 6) fp = 6;
                fp = fp + p_indep;
                first = byte_count(a) > fp ? byte_count(a) - fp : 0;
            end
            cur_byte = first;
            marked[a] = 1'b0;
            ring_used--;
            ring_rd = (ring_rd + 1) % RING_SIZE;
        end
        a = cur_value;
        if (a == crws_pkg::UPDATE_VALUE) ofs = 2;
        else if (a == crws_pkg::RESET_STROBE) ofs = 0;
        else if (a == crws_pkg::LATCH_STROBE) ofs = 3;
        else ofs = 1;
        len = byte_count(a);
        regnum = 8'(REG_TAB[a] - p_indep + len - cur_byte - 1);
        if (keying) regnum = regnum + crws_pkg::KEY_BIT;
        if (holding) regnum = regnum + crws_pkg::HOLD_BIT;
        dbyte = 8'(cur_contents >> (8 * cur_byte));
        cur_byte++;
        if (cur_byte >= len)
        begin
            if (a != crws_pkg::RESET_STROBE && a != crws_pkg::LATCH_STROBE) ofs++;
            cur_value = crws_pkg::IDLE_MARK;
            cur_byte = 0;
        end
        r.wv = 1'b1;
        r.addr = p_base + 16'(4 * p_dev) + 16'(ofs);
        r.data = {dbyte, regnum};
    endfunction

    function automatic bus_result_t predict_command(command_t c);
        bus_result_t r;
        r = '{1'b0, 16'h0, 16'h0, 48'h0, 1'b0};
        if (!p_enable)
            return r;
        case (c.op)
            crws_pkg::OP_SET:
                if (c.idx < NUM_VALUES && (shadow[c.idx] != c.val || p_force))
                begin
                    if (ring_used >= RING_SIZE)
                        r.ovf = 1'b1;
                    else
                    begin
                        shadow[c.idx] = c.val;
                        if (!marked[c.idx])
                        begin
                            void'(enqueue(c.idx));
                            marked[c.idx] = 1'b1;
                        end
                    end
                end
            crws_pkg::OP_TICK:
                emit_byte(r);
            crws_pkg::OP_MRESET:
                if (ring_used >= RING_SIZE)
                    r.ovf = 1'b1;
                else
                begin
                    clear_shadows();
                    void'(enqueue(crws_pkg::RESET_STROBE));
                end
            crws_pkg::OP_LATCH:
                r.ovf = !enqueue(crws_pkg::LATCH_STROBE);
            crws_pkg::OP_KEY:
            begin
                keying = c.flag;
                r.ovf = !enqueue(crws_pkg::LATCH_STROBE);
                r.rdata = {47'h0, keying};
            end
            crws_pkg::OP_HOLD:
            begin
                holding = c.flag;
                r.ovf = !enqueue(crws_pkg::LATCH_STROBE);
                r.rdata = {47'h0, holding};
            end
            crws_pkg::OP_READ:
                if (c.idx < NUM_VALUES)
                    r.rdata = shadow[c.idx];
            default: ;
        endcase
        return r;
    endfunction

    command_t    pending_cmds[$];
    bus_result_t expected_results[$];
    int          accept_count;
    int          seen_count;
    bit          presenting;
    int          gap_left;
    command_t    cur_cmd;
    int          mismatches;
    int          cycles;

    // monitor: sample at rising edge
    always @(posedge clk)
    begin
        bus_result_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result strobe at cycle %0d", cycles);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (write_valid !== e.wv || bus_address !== e.addr
                        || bus_data !== e.data || read_data !== e.rdata
                        || overflow !== e.ovf)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp wv=%0b a=%h d=%h r=%h o=%0b",
                                      " got wv=%0b a=%h d=%h r=%h o=%0b"},
                                e.wv, e.addr, e.data, e.rdata, e.ovf,
                                write_valid, bus_address, bus_data, read_data, overflow);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(predict_command(
                    command_t'{opcode, value_index, value, flag_value}));
                accept_count++;
            end
            if (cfg_we)
                case (cfg_index)
                    crws_pkg::CFG_ENABLE: p_enable = cfg_data[0];
                    crws_pkg::CFG_FORCE:  p_force = cfg_data[0];
                    crws_pkg::CFG_INDEP:  p_indep = cfg_data[0];
                    crws_pkg::CFG_PREC:   p_prec = cfg_data[2:0];
                    crws_pkg::CFG_DEVICE: p_dev = cfg_data[5:0];
                    crws_pkg::CFG_BASE:   p_base = cfg_data;
                    default: ;
                endcase
        end
    end

    // driver: change inputs at falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (presenting && accept_count != seen_count)
            begin
                seen_count = accept_count;
                presenting = 1'b0;
                gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            end
            if (!presenting)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() != 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    presenting = 1'b1;
                end
            end
            start <= presenting;
            opcode <= cur_cmd.op;
            value_index <= cur_cmd.idx;
            value <= cur_cmd.val;
            flag_value <= cur_cmd.flag;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("coalescing_register_write_serializer_unit_test NOT OK");
            $finish;
        end
    end

    task automatic add_cmd(logic [2:0] op, logic [4:0] idx, logic [47:0] val, logic flag);
        pending_cmds.push_back('{op, idx, val, flag});
    endtask

    task automatic wait_drained();
        wait (pending_cmds.size() == 0 && !presenting && expected_results.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_random(int count);
        int r;
        logic [4:0] idx;
        logic [47:0] val;
        logic flag;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
            flag = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: val = 48'h0;
                1: val = 48'($urandom_range(0, 3));
                default: val = {16'($urandom), 32'($urandom)};
            endcase
            if (r < 35) add_cmd(crws_pkg::OP_SET, idx, val, 1'b0);
            else if (r < 75) add_cmd(crws_pkg::OP_TICK, idx, val, flag);
            else if (r < 77) add_cmd(crws_pkg::OP_MRESET, idx, val, flag);
            else if (r < 81) add_cmd(crws_pkg::OP_LATCH, idx, val, flag);
            else if (r < 85) add_cmd(crws_pkg::OP_KEY, idx, val, flag);
            else if (r < 89) add_cmd(crws_pkg::OP_HOLD, idx, val, flag);
            else if (r < 98) add_cmd(crws_pkg::OP_READ, idx, val, flag);
            else add_cmd(OP_UNUSED, idx, val, flag);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = crws_pkg::OP_SET;
        value_index = '0;
        value = '0;
        flag_value = 1'b0;
        cfg_we = 1'b0;
        cfg_index = crws_pkg::CFG_ENABLE;
        cfg_data = '0;
        cur_cmd = '{crws_pkg::OP_SET, 5'd0, 48'h0, 1'b0};
        accept_count = 0;
        seen_count = 0;
        presenting = 1'b0;
        gap_left = 0;
        mismatches = 0;
        cycles = 0;
        p_enable = 1'b1;
        p_force = 1'b0;
        p_indep = 1'b0;
        p_prec = 3'd6;
        p_dev = '0;
        p_base = '0;
        clear_shadows();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every opcode but latch, idle tick, out-of-range index
        add_cmd(crws_pkg::OP_TICK, 5'd0, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_READ, 5'd5, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_READ, 5'd31, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_cmd(crws_pkg::OP_SET, 5'd2, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_cmd(crws_pkg::OP_SET, 5'd2, 48'h0123_4567_89AB, 1'b0);
        add_cmd(crws_pkg::OP_SET, 5'd17, 48'h55, 1'b0);
        add_cmd(crws_pkg::OP_SET, 5'd5, 48'h40, 1'b0);
        add_cmd(crws_pkg::OP_KEY, 5'd0, 48'h0, 1'b1);
        add_cmd(crws_pkg::OP_HOLD, 5'd0, 48'h0, 1'b1);
        add_cmd(OP_UNUSED, 5'd3, 48'h0, 1'b0);
        for (int i = 0; i < 10; i++)
            add_cmd(crws_pkg::OP_TICK, 5'd0, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_MRESET, 5'd0, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_READ, 5'd11, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_TICK, 5'd0, 48'h0, 1'b0);
        // fill the queue, then a dropped set, a dropped reset and a flag change
        for (int i = 0; i < 33; i++)
            add_cmd(crws_pkg::OP_LATCH, 5'd0, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_SET, 5'd4, 48'h77, 1'b0);
        add_cmd(crws_pkg::OP_MRESET, 5'd0, 48'h0, 1'b0);
        add_cmd(crws_pkg::OP_KEY, 5'd0, 48'h0, 1'b1);
        for (int i = 0; i < 34; i++)
            add_cmd(crws_pkg::OP_TICK, 5'd0, 48'h0, 1'b0);
        wait_drained();

        add_random(150);
        wait_drained();

        write_reg(crws_pkg::CFG_FORCE, 16'h1);
        write_reg(crws_pkg::CFG_INDEP, 16'h1);
        write_reg(crws_pkg::CFG_PREC, 16'h0);
        write_reg(crws_pkg::CFG_DEVICE, 16'h3F);
        write_reg(crws_pkg::CFG_BASE, 16'hFFFF);
        add_random(150);
        wait_drained();

        write_reg(crws_pkg::CFG_PREC, 16'h7);
        write_reg(crws_pkg::CFG_FORCE, 16'h0);
        add_random(150);
        wait_drained();

        write_reg(crws_pkg::CFG_ENABLE, 16'h0);
        add_random(40);
        wait_drained();

        write_reg(crws_pkg::CFG_ENABLE, 16'h1);
        write_reg(crws_pkg::CFG_INDEP, 16'h0);
        write_reg(crws_pkg::CFG_PREC, 16'h1);
        write_reg(crws_pkg::CFG_DEVICE, 16'($urandom_range(0, 63)));
        write_reg(crws_pkg::CFG_BASE, 16'($urandom));
        add_random(130);
        wait_drained();

        write_reg(crws_pkg::CFG_PREC, 16'h3);
        write_reg(crws_pkg::CFG_FORCE, 16'h1);
        add_random(130);
        wait_drained();

        if (mismatches == 0)
            $display("coalescing_register_write_serializer_unit_test OK");
        else
            $display("coalescing_register_write_serializer_unit_test NOT OK");
        $finish;
    end

endmodule

// ----- coalescing_register_write_serializer_unit.f -----
+incdir+rtl
rtl/crws_pkg.sv
rtl/crws_ram.sv
rtl/crws_queue.sv
rtl/crws_back.sv
rtl/coalescing_register_write_serializer_unit.sv
tb/coalescing_register_write_serializer_unit_test.sv
